FILE: rtl/core/ipsv_pkg.sv
// Shared types and constants for the inverse Park / SVPWM modulator.
// Holds the CORDIC arctangent table, datapath widths and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package ipsv_pkg;

    // CORDIC datapath
    localparam int CW     = 33;   // x/y width, gain-compensated 2^30 scale
    localparam int ZW     = 33;   // residual angle, 2^32 units per turn
    localparam int NUM_IT = 30;
    localparam logic signed [CW-1:0] GAIN_INV = 33'sd652032874;

    localparam logic [31:0] ATAN_TURN32 [0:NUM_IT-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    localparam logic [16:0] SQRT3_HALF_Q17 = 17'd113512;

    // duty / divider datapath
    localparam int LANES  = 3;
    localparam int BUS_W  = 16;
    localparam int PER_W  = 17;
    localparam int DEN_W  = 24;   // bus * 256
    localparam int PROD_W = DEN_W + PER_W;
    localparam int Q_W    = 17;

    typedef logic [LANES-1:0][PROD_W-1:0] rem_vec_t;
    typedef logic [LANES-1:0][Q_W-1:0]    quo_vec_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BUS_VOLTAGE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD  = 1'b1;

    localparam logic [BUS_W-1:0] BUS_RESET    = 16'd3072;
    localparam logic [PER_W-1:0] PERIOD_RESET = 17'd4250;
    localparam logic [BUS_W-1:0] BUS_MIN      = 16'd256;

endpackage

FILE: rtl/core/ipsv_cordic_cell.sv
// One rotation step of the sine/cosine CORDIC chain.
// Depends on ipsv_pkg (widths, arctangent table).
`timescale 1ns / 1ps

module ipsv_cordic_cell #(
    parameter int STAGE = 0,
    parameter int PW    = 34
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [ipsv_pkg::CW-1:0] x_in,
    input  logic signed [ipsv_pkg::CW-1:0] y_in,
    input  logic signed [ipsv_pkg::ZW-1:0] z_in,
    input  logic        [PW-1:0]           pass_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [ipsv_pkg::CW-1:0] x_out,
    output logic signed [ipsv_pkg::CW-1:0] y_out,
    output logic signed [ipsv_pkg::ZW-1:0] z_out,
    output logic        [PW-1:0]           pass_out
);
    import ipsv_pkg::*;

    logic                 valid_reg;
    logic signed [CW-1:0] x_reg, y_reg, x_next, y_next, dx, dy;
    logic signed [ZW-1:0] z_reg, z_next, atan;
    logic        [PW-1:0] pass_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        dx   = y_in >>> STAGE;
        dy   = x_in >>> STAGE;
        atan = $signed({1'b0, ATAN_TURN32[STAGE]});
        if (!z_in[ZW-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - atan;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + atan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            pass_reg <= pass_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign pass_out  = pass_reg;

endmodule

FILE: rtl/core/ipsv_div_cell.sv
// One restoring-division step, three phase lanes sharing one divisor.
// Depends on ipsv_pkg (widths, lane vector types).
`timescale 1ns / 1ps

module ipsv_div_cell #(
    parameter int K = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ipsv_pkg::DEN_W-1:0]   den_in,
    input  ipsv_pkg::rem_vec_t           rem_in,
    input  ipsv_pkg::quo_vec_t           quo_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ipsv_pkg::DEN_W-1:0]   den_out,
    output ipsv_pkg::rem_vec_t           rem_out,
    output ipsv_pkg::quo_vec_t           quo_out
);
    import ipsv_pkg::*;

    logic              valid_reg;
    logic [DEN_W-1:0]  den_reg;
    rem_vec_t          rem_reg, rem_next;
    quo_vec_t          quo_reg, quo_next;
    logic [PROD_W-1:0] trial;

    assign in_ready = !valid_reg || out_ready;
    assign trial    = PROD_W'(den_in) << K;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (rem_in[l] >= trial)
            begin
                rem_next[l] = rem_in[l] - trial;
                quo_next[l] = quo_in[l] | (Q_W'(1) << K);
            end
            else
            begin
                rem_next[l] = rem_in[l];
                quo_next[l] = quo_in[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            den_reg <= den_in;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign den_out   = den_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;

endmodule

FILE: rtl/core/inverse_park_svpwm_modulator.sv
// Pipeline: 30 CORDIC cells, 9 datapath stages, 17 divider cells.
// Throughput: one transaction per cycle while m_tready is high; every stage holds
// a valid bit and advances when the next stage is free, so bubbles collapse under stall.
// Reset: rst_n async active low clears all valid bits and loads bus_voltage
// 3072 and pwm_period 4250. Depends on ipsv_pkg, ipsv_cordic_cell, ipsv_div_cell.
`timescale 1ns / 1ps

module inverse_park_svpwm_modulator #(
    parameter int TRIG_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [47:0]                     s_tdata,   // volt_d, volt_q, rotor_angle
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [55:0]                     m_tdata,   // compare_a, compare_b, compare_c
    input  logic                            cfg_we,
    input  logic [ipsv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [16:0]                     cfg_data
);
    import ipsv_pkg::*;

    localparam int SH   = 30 - TRIG_BITS;      // CORDIC output rounding shift
    localparam int CSW  = TRIG_BITS + 2;       // sin/cos width
    localparam int PRW  = 16 + CSW;            // Park product width
    localparam int VW   = PRW + 1;             // alpha/beta width
    localparam int UW   = TRIG_BITS + 38;      // Clarke / centring width
    localparam int RSH  = TRIG_BITS + 10;      // centred phase rounding shift
    localparam int RW   = UW - RSH;            // rounded phase width
    localparam int NW   = RW + 1;
    localparam int PASS = 34;
    localparam int NMID = 9;

    // configuration
    logic [BUS_W-1:0] bus_reg;
    logic [PER_W-1:0] period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg    <= BUS_RESET;
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BUS_VOLTAGE: bus_reg    <= cfg_data[BUS_W-1:0];
                REG_PWM_PERIOD:  period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // CORDIC chain
    logic                 c_valid [0:NUM_IT];
    logic                 c_ready [0:NUM_IT];
    logic signed [CW-1:0] c_x     [0:NUM_IT];
    logic signed [CW-1:0] c_y     [0:NUM_IT];
    logic signed [ZW-1:0] c_z     [0:NUM_IT];
    logic [PASS-1:0]      c_pass  [0:NUM_IT];

    assign c_valid[0] = s_tvalid;
    assign s_tready   = c_ready[0];
    assign c_x[0]     = GAIN_INV;
    assign c_y[0]     = '0;
    assign c_z[0]     = $signed({3'b000, s_tdata[45:32], 16'h0000});
    assign c_pass[0]  = {s_tdata[47:46], s_tdata[31:0]};

    for (genvar i = 0; i < NUM_IT; i++)
    begin : g_cordic
        ipsv_cordic_cell #(.STAGE(i), .PW(PASS)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (c_valid[i]),
            .in_ready (c_ready[i]),
            .x_in     (c_x[i]),
            .y_in     (c_y[i]),
            .z_in     (c_z[i]),
            .pass_in  (c_pass[i]),
            .out_valid(c_valid[i+1]),
            .out_ready(c_ready[i+1]),
            .x_out    (c_x[i+1]),
            .y_out    (c_y[i+1]),
            .z_out    (c_z[i+1]),
            .pass_out (c_pass[i+1])
        );
    end

    // datapath stages
    logic [NMID-1:0] v_mid_reg;
    logic [NMID:0]   rdy_mid;
    logic [NMID-1:0] vin_mid;
    logic            d_ready0;

    assign rdy_mid[NMID] = d_ready0;
    for (genvar s = 0; s < NMID; s++)
    begin : g_rdy
        assign rdy_mid[s] = !v_mid_reg[s] || rdy_mid[s+1];
        if (s == 0)
        begin : g_first
            assign vin_mid[s] = c_valid[NUM_IT];
        end
        else
        begin : g_rest
            assign vin_mid[s] = v_mid_reg[s-1];
        end
    end
    assign c_ready[NUM_IT] = rdy_mid[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_mid_reg <= '0;
        else
        begin
            for (int s = 0; s < NMID; s++)
                if (rdy_mid[s])
                    v_mid_reg[s] <= vin_mid[s];
        end
    end

    // stage 0: quadrant fold and rounding
    logic signed [CW-1:0]  cxq, syq, cs_full, sn_full;
    logic signed [CSW-1:0] cs_reg, sn_reg;
    logic signed [15:0]    vd0_reg, vq0_reg, vd1_reg, vq1_reg;
    logic [1:0]            quad;

    assign quad = c_pass[NUM_IT][33:32];

    always_comb
    begin
        case (quad)
            2'd0:    begin cxq = c_x[NUM_IT];  syq = c_y[NUM_IT];  end
            2'd1:    begin cxq = -c_y[NUM_IT]; syq = c_x[NUM_IT];  end
            2'd2:    begin cxq = -c_x[NUM_IT]; syq = -c_y[NUM_IT]; end
            default: begin cxq = c_y[NUM_IT];  syq = -c_x[NUM_IT]; end
        endcase
        cs_full = (cxq + (CW'(1) <<< (SH - 1))) >>> SH;
        sn_full = (syq + (CW'(1) <<< (SH - 1))) >>> SH;
    end

    // stage 1: Park products
    logic signed [PRW-1:0] p_dc_reg, p_qs_reg, p_ds_reg, p_qc_reg;
    // stage 2: alpha/beta
    logic signed [VW-1:0]  va_reg, vb_reg;
    // stage 3: Clarke
    logic signed [UW-1:0]  va_ext, vb_ext, vbk;
    logic signed [UW-1:0]  ua_reg, ub_reg, uc_reg;
    // stage 4: min/max midpoint
    logic signed [UW-1:0]  mn, mx;
    logic signed [UW-1:0]  ua4_reg, ub4_reg, uc4_reg, mid2_reg;
    // stage 5: centring
    logic signed [UW-1:0]  cen_reg [0:LANES-1];
    // stage 6: rounding to Q.8
    logic signed [UW-1:0]  rnd_full [0:LANES-1];
    logic signed [RW-1:0]  u_reg [0:LANES-1];
    // stage 7: duty numerator clamp
    logic [BUS_W-1:0]      b_eff;
    logic signed [NW-1:0]  num_raw [0:LANES-1];
    logic [DEN_W-1:0]      den_next, den7_reg, den8_reg;
    logic [DEN_W-1:0]      num_reg [0:LANES-1];
    // stage 8: numerator times period
    rem_vec_t              prod_reg;

    assign va_ext = UW'(va_reg);
    assign vb_ext = UW'(vb_reg);
    assign vbk    = vb_ext * $signed({1'b0, SQRT3_HALF_Q17});

    always_comb
    begin
        mn = ua_reg;
        if (ub_reg < mn) mn = ub_reg;
        if (uc_reg < mn) mn = uc_reg;
        mx = ua_reg;
        if (ub_reg > mx) mx = ub_reg;
        if (uc_reg > mx) mx = uc_reg;
    end

    assign b_eff    = (bus_reg < BUS_MIN) ? BUS_MIN : bus_reg;
    assign den_next = {b_eff, 8'h00};

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        assign rnd_full[l] = (cen_reg[l] + (UW'(1) <<< (RSH - 1))) >>> RSH;
        assign num_raw[l]  = NW'(u_reg[l]) + $signed(NW'({b_eff, 7'h00}));
    end

    always_ff @(posedge clk)
    begin
        if (rdy_mid[0])
        begin
            cs_reg  <= cs_full[CSW-1:0];
            sn_reg  <= sn_full[CSW-1:0];
            vd0_reg <= c_pass[NUM_IT][15:0];
            vq0_reg <= c_pass[NUM_IT][31:16];
        end
        if (rdy_mid[1])
        begin
            p_dc_reg <= PRW'(vd0_reg) * PRW'(cs_reg);
            p_qs_reg <= PRW'(vq0_reg) * PRW'(sn_reg);
            p_ds_reg <= PRW'(vd0_reg) * PRW'(sn_reg);
            p_qc_reg <= PRW'(vq0_reg) * PRW'(cs_reg);
        end
        if (rdy_mid[2])
        begin
            va_reg <= VW'(p_dc_reg) - VW'(p_qs_reg);
            vb_reg <= VW'(p_ds_reg) + VW'(p_qc_reg);
        end
        if (rdy_mid[3])
        begin
            ua_reg <= va_ext <<< 17;
            ub_reg <= vbk - (va_ext <<< 16);
            uc_reg <= -(va_ext <<< 16) - vbk;
        end
        if (rdy_mid[4])
        begin
            ua4_reg  <= ua_reg;
            ub4_reg  <= ub_reg;
            uc4_reg  <= uc_reg;
            mid2_reg <= mn + mx;
        end
        if (rdy_mid[5])
        begin
            cen_reg[0] <= (ua4_reg <<< 1) - mid2_reg;
            cen_reg[1] <= (ub4_reg <<< 1) - mid2_reg;
            cen_reg[2] <= (uc4_reg <<< 1) - mid2_reg;
        end
        if (rdy_mid[6])
        begin
            for (int l = 0; l < LANES; l++)
                u_reg[l] <= rnd_full[l][RW-1:0];
        end
        if (rdy_mid[7])
        begin
            den7_reg <= den_next;
            for (int l = 0; l < LANES; l++)
            begin
                if (num_raw[l][NW-1])
                    num_reg[l] <= '0;
                else if (num_raw[l] > $signed(NW'(den_next)))
                    num_reg[l] <= den_next;
                else
                    num_reg[l] <= num_raw[l][DEN_W-1:0];
            end
        end
        if (rdy_mid[8])
        begin
            den8_reg <= den7_reg;
            for (int l = 0; l < LANES; l++)
                prod_reg[l] <= PROD_W'(num_reg[l]) * PROD_W'(period_reg);
        end
    end

    // divider chain, quotient MSB first
    logic             d_valid [0:Q_W];
    logic             d_ready [0:Q_W];
    logic [DEN_W-1:0] d_den   [0:Q_W];
    rem_vec_t         d_rem   [0:Q_W];
    quo_vec_t         d_quo   [0:Q_W];

    assign d_valid[0] = v_mid_reg[NMID-1];
    assign d_ready0   = d_ready[0];
    assign d_den[0]   = den8_reg;
    assign d_rem[0]   = prod_reg;
    assign d_quo[0]   = '0;

    for (genvar j = 0; j < Q_W; j++)
    begin : g_div
        ipsv_div_cell #(.K(Q_W - 1 - j)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (d_valid[j]),
            .in_ready (d_ready[j]),
            .den_in   (d_den[j]),
            .rem_in   (d_rem[j]),
            .quo_in   (d_quo[j]),
            .out_valid(d_valid[j+1]),
            .out_ready(d_ready[j+1]),
            .den_out  (d_den[j+1]),
            .rem_out  (d_rem[j+1]),
            .quo_out  (d_quo[j+1])
        );
    end

    assign d_ready[Q_W] = m_tready;
    assign m_tvalid     = d_valid[Q_W];
    assign m_tdata      = {5'b00000, d_quo[Q_W][2], d_quo[Q_W][1], d_quo[Q_W][0]};

`ifndef SYNTHESIS
    a_cmp_a_le_period: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (d_quo[Q_W][0] <= period_reg))
        else $error("compare_a above period");
    a_cmp_b_le_period: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (d_quo[Q_W][1] <= period_reg))
        else $error("compare_b above period");
    a_num_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        v_mid_reg[7] |-> (num_reg[0] <= den7_reg && num_reg[2] <= den7_reg))
        else $error("duty numerator outside clamp");
    a_den_floor: assert property (@(posedge clk) disable iff (!rst_n)
        v_mid_reg[8] |-> (den8_reg >= {BUS_MIN, 8'h00}))
        else $error("divisor below low-bus floor");
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (c_valid[1] && !m_tready))
        else $error("input stalled with free head stage");
`endif

endmodule
